// ----- sv/assert_macros.svh -----
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define SRLB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent, outside reset
`define SRLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ante |=> cons) else $error(msg);

`endif

// ----- sv/srlb_pkg.sv -----
// shared widths, defaults and operation codes of the ring log buffer
package srlb_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int MSG_MAX_DEF = 32;

  localparam int SEQ_W  = 32;
  localparam int SEV_W  = 3;
  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

endpackage

// ----- sv/srlb_meta_ram.sv -----
// per-slot tag, severity and length store with tag valid bits
module srlb_meta_ram #(
  parameter int SLOTS = srlb_pkg::SLOTS_DEF,
  parameter int LW    = 6
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           clr_en,
  input  logic                           wr_en,
  input  logic [$clog2(SLOTS)-1:0]       wr_slot,
  input  logic [srlb_pkg::SEQ_W-1:0]     wr_tag,
  input  logic [srlb_pkg::SEV_W-1:0]     wr_sev,
  input  logic [LW-1:0]                  wr_len,
  input  logic                           rd_en,
  input  logic [$clog2(SLOTS)-1:0]       rd_slot,
  output logic                           rd_valid,
  output logic [srlb_pkg::SEQ_W-1:0]     rd_tag,
  output logic [srlb_pkg::SEV_W-1:0]     rd_sev,
  output logic [LW-1:0]                  rd_len
);

  localparam int DW = srlb_pkg::SEQ_W + srlb_pkg::SEV_W + LW;

  logic [DW-1:0]    mem [SLOTS];
  logic [SLOTS-1:0] valid_r;
  logic [DW-1:0]    rd_word_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_slot] <= {wr_tag, wr_sev, wr_len};
    end
    if (rd_en) begin
      rd_word_r <= mem[rd_slot];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_slot] <= 1'b1;
      end else if (clr_en) begin
        valid_r[wr_slot] <= 1'b0;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_slot];
      end
    end
  end

  assign rd_valid = rd_valid_r;
  assign rd_tag   = rd_word_r[DW-1 -: srlb_pkg::SEQ_W];
  assign rd_sev   = rd_word_r[LW +: srlb_pkg::SEV_W];
  assign rd_len   = rd_word_r[LW-1:0];

endmodule

// ----- sv/srlb_text_ram.sv -----
// message text store, one write and one registered read port
module srlb_text_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [srlb_pkg::BYTE_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [srlb_pkg::BYTE_W-1:0] rdata
);

  logic [srlb_pkg::BYTE_W-1:0] mem [DEPTH];
  logic [srlb_pkg::BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/sequenced_ring_log_buffer.sv -----
// ring log buffer top level: append path and drain sequencer
// append: takes one transaction per cycle, in_ready stays high
// drain: clamp and slot setup, then meta read and check per scanned slot (at most SLOTS)
// each result byte: text read, wait, then output until out_ready; not ready while draining
// reset (rst_n low, synchronous) clears all tag valid bits at once, no clearing pass
// next sequence resets to one; text memory content is undefined until written
module sequenced_ring_log_buffer #(
  parameter int SLOTS   = srlb_pkg::SLOTS_DEF,
  parameter int MSG_MAX = srlb_pkg::MSG_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_operation,
  input  logic [srlb_pkg::SEV_W-1:0]   in_entry_severity,
  input  logic [srlb_pkg::BYTE_W-1:0]  in_msg_byte,
  input  logic                         in_msg_last,
  input  logic [srlb_pkg::SEQ_W-1:0]   in_cursor,
  input  logic [srlb_pkg::SEV_W-1:0]   in_min_severity,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_found,
  output logic [srlb_pkg::SEV_W-1:0]   out_severity,
  output logic [srlb_pkg::BYTE_W-1:0]  out_byte,
  output logic                         out_byte_valid,
  output logic [srlb_pkg::LEN_W-1:0]   out_message_length,
  output logic [srlb_pkg::SEQ_W-1:0]   out_new_cursor,
  output logic                         out_last
);

  localparam int SW    = $clog2(SLOTS);
  localparam int IW    = (MSG_MAX > 1) ? $clog2(MSG_MAX) : 1;
  localparam int LW    = $clog2(MSG_MAX + 1);
  localparam int TW    = SW + IW;
  localparam int TDEP  = SLOTS * (1 << IW);
  localparam int QW    = srlb_pkg::SEQ_W;

  localparam logic [QW-1:0]   SLOTS_Q   = QW'(SLOTS);
  localparam logic [QW-1:0]   ONE_Q     = QW'(1);
  localparam logic [SW:0]     SLOTS_D   = (SW+1)'(SLOTS);
  localparam logic [SW-1:0]   SLOT_LAST = SW'(SLOTS - 1);
  localparam logic [SW-1:0]   SLOT_ONE  = SW'(1);
  localparam logic [LW-1:0]   MSG_MAX_L = LW'(MSG_MAX);
  localparam logic [LW-1:0]   LEN_ONE   = LW'(1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_CLAMP    = 3'd1;
  localparam logic [2:0] ST_SLOT     = 3'd2;
  localparam logic [2:0] ST_SCAN_RD  = 3'd3;
  localparam logic [2:0] ST_SCAN_CHK = 3'd4;
  localparam logic [2:0] ST_TXT_RD   = 3'd5;
  localparam logic [2:0] ST_TXT_WAIT = 3'd6;
  localparam logic [2:0] ST_OUT      = 3'd7;

  logic [2:0]                  state_r, state_nxt;
  logic [QW-1:0]               next_seq_r, next_seq_nxt;
  logic [SW-1:0]               next_slot_r, next_slot_nxt;
  logic [LW-1:0]               fill_r, fill_nxt;
  logic                        ended_r, ended_nxt;
  logic [QW-1:0]               s_r, s_nxt;
  logic [QW-1:0]               oldest_r, oldest_nxt;
  logic [QW-1:0]               cur_r, cur_nxt;
  logic [srlb_pkg::SEV_W-1:0]  minsev_r, minsev_nxt;
  logic [SW-1:0]               slot_r, slot_nxt;
  logic [LW-1:0]               idx_r, idx_nxt;
  logic [srlb_pkg::SEV_W-1:0]  sev_r, sev_nxt;
  logic [LW-1:0]               len_r, len_nxt;

  logic                        o_found_r, o_found_nxt;
  logic [srlb_pkg::SEV_W-1:0]  o_sev_r, o_sev_nxt;
  logic [srlb_pkg::BYTE_W-1:0] o_byte_r, o_byte_nxt;
  logic                        o_bv_r, o_bv_nxt;
  logic [LW-1:0]               o_len_r, o_len_nxt;
  logic [QW-1:0]               o_cur_r, o_cur_nxt;
  logic                        o_last_r, o_last_nxt;

  logic                        app;
  logic                        store;
  logic [LW-1:0]               commit_len;
  logic [QW-1:0]               seq_inc;
  logic [SW-1:0]               slot_inc;
  logic [SW-1:0]               scan_slot_inc;
  logic                        in_range;
  logic [SW:0]                 back_dist;
  logic [SW:0]                 base;
  logic [SW:0]                 slot_calc;

  logic                        meta_rd_en;
  logic                        meta_valid;
  logic [QW-1:0]               meta_tag;
  logic [srlb_pkg::SEV_W-1:0]  meta_sev;
  logic [LW-1:0]               meta_len;
  logic                        text_rd_en;
  logic [srlb_pkg::BYTE_W-1:0] text_rdata;

  assign in_ready = (state_r == ST_IDLE);
  assign app      = in_valid && in_ready && (in_operation == srlb_pkg::OP_APPEND);
  assign store    = (in_msg_byte != '0) && !ended_r && (fill_r < MSG_MAX_L);
  assign commit_len = store ? (fill_r + LEN_ONE) : fill_r;
  assign seq_inc  = next_seq_r + ONE_Q;
  assign slot_inc = (next_slot_r == SLOT_LAST) ? '0 : (next_slot_r + SLOT_ONE);
  assign scan_slot_inc = (slot_r == SLOT_LAST) ? '0 : (slot_r + SLOT_ONE);
  assign in_range = (s_r < next_seq_r);

  // slot of s from the distance back from the next sequence
  assign back_dist = (SW+1)'(next_seq_r - s_r);
  assign base = {1'b0, next_slot_r};
  assign slot_calc = (base < back_dist) ? (base + SLOTS_D - back_dist) : (base - back_dist);

  assign meta_rd_en = (state_r == ST_SCAN_RD) && in_range;
  assign text_rd_en = (state_r == ST_TXT_RD);

  srlb_meta_ram #(
    .SLOTS (SLOTS),
    .LW    (LW)
  ) u_meta (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr_en   (app),
    .wr_en    (app && in_msg_last),
    .wr_slot  (next_slot_r),
    .wr_tag   (next_seq_r),
    .wr_sev   (in_entry_severity),
    .wr_len   (commit_len),
    .rd_en    (meta_rd_en),
    .rd_slot  (slot_r),
    .rd_valid (meta_valid),
    .rd_tag   (meta_tag),
    .rd_sev   (meta_sev),
    .rd_len   (meta_len)
  );

  srlb_text_ram #(
    .DEPTH (TDEP),
    .AW    (TW)
  ) u_text (
    .clk   (clk),
    .we    (app && store),
    .waddr ({next_slot_r, fill_r[IW-1:0]}),
    .wdata (in_msg_byte),
    .re    (text_rd_en),
    .raddr ({slot_r, idx_r[IW-1:0]}),
    .rdata (text_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    next_seq_nxt  = next_seq_r;
    next_slot_nxt = next_slot_r;
    fill_nxt      = fill_r;
    ended_nxt     = ended_r;
    s_nxt         = s_r;
    oldest_nxt    = oldest_r;
    cur_nxt       = cur_r;
    minsev_nxt    = minsev_r;
    slot_nxt      = slot_r;
    idx_nxt       = idx_r;
    sev_nxt       = sev_r;
    len_nxt       = len_r;
    o_found_nxt   = o_found_r;
    o_sev_nxt     = o_sev_r;
    o_byte_nxt    = o_byte_r;
    o_bv_nxt      = o_bv_r;
    o_len_nxt     = o_len_r;
    o_cur_nxt     = o_cur_r;
    o_last_nxt    = o_last_r;

    case (state_r)
      ST_IDLE: begin
        if (app) begin
          if (in_msg_byte == '0) begin
            ended_nxt = 1'b1;
          end else if (store) begin
            fill_nxt = fill_r + LEN_ONE;
          end
          if (in_msg_last) begin
            fill_nxt  = '0;
            ended_nxt = 1'b0;
            if (seq_inc == '0) begin
              next_seq_nxt  = ONE_Q;
              next_slot_nxt = SLOT_ONE;
            end else begin
              next_seq_nxt  = seq_inc;
              next_slot_nxt = slot_inc;
            end
          end
        end else if (in_valid) begin
          s_nxt      = in_cursor + ONE_Q;
          oldest_nxt = (next_seq_r > SLOTS_Q) ? (next_seq_r - SLOTS_Q) : ONE_Q;
          cur_nxt    = in_cursor;
          minsev_nxt = in_min_severity;
          state_nxt  = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        if (s_r < oldest_r) begin
          s_nxt = oldest_r;
        end
        state_nxt = ST_SLOT;
      end
      ST_SLOT: begin
        slot_nxt  = slot_calc[SW-1:0];
        state_nxt = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        if (in_range) begin
          state_nxt = ST_SCAN_CHK;
        end else begin
          o_found_nxt = 1'b0;
          o_sev_nxt   = '0;
          o_byte_nxt  = '0;
          o_bv_nxt    = 1'b0;
          o_len_nxt   = '0;
          o_cur_nxt   = cur_r;
          o_last_nxt  = 1'b1;
          state_nxt   = ST_OUT;
        end
      end
      ST_SCAN_CHK: begin
        if (meta_valid && (meta_tag == s_r) && (meta_sev >= minsev_r)) begin
          cur_nxt = s_r;
          sev_nxt = meta_sev;
          len_nxt = meta_len;
          idx_nxt = '0;
          if (meta_len == '0) begin
            o_found_nxt = 1'b1;
            o_sev_nxt   = meta_sev;
            o_byte_nxt  = '0;
            o_bv_nxt    = 1'b0;
            o_len_nxt   = '0;
            o_cur_nxt   = s_r;
            o_last_nxt  = 1'b1;
            state_nxt   = ST_OUT;
          end else begin
            state_nxt = ST_TXT_RD;
          end
        end else begin
          if (meta_valid && (meta_tag == s_r)) begin
            cur_nxt = s_r;
          end
          s_nxt     = s_r + ONE_Q;
          slot_nxt  = scan_slot_inc;
          state_nxt = ST_SCAN_RD;
        end
      end
      ST_TXT_RD: begin
        state_nxt = ST_TXT_WAIT;
      end
      ST_TXT_WAIT: begin
        o_found_nxt = 1'b1;
        o_sev_nxt   = sev_r;
        o_byte_nxt  = text_rdata;
        o_bv_nxt    = 1'b1;
        o_len_nxt   = len_r;
        o_cur_nxt   = cur_r;
        o_last_nxt  = ((idx_r + LEN_ONE) == len_r);
        state_nxt   = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          if (o_last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + LEN_ONE;
            state_nxt = ST_TXT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      next_seq_r  <= ONE_Q;
      next_slot_r <= SLOT_ONE;
      fill_r      <= '0;
      ended_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_seq_r  <= next_seq_nxt;
      next_slot_r <= next_slot_nxt;
      fill_r      <= fill_nxt;
      ended_r     <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r       <= s_nxt;
    oldest_r  <= oldest_nxt;
    cur_r     <= cur_nxt;
    minsev_r  <= minsev_nxt;
    slot_r    <= slot_nxt;
    idx_r     <= idx_nxt;
    sev_r     <= sev_nxt;
    len_r     <= len_nxt;
    o_found_r <= o_found_nxt;
    o_sev_r   <= o_sev_nxt;
    o_byte_r  <= o_byte_nxt;
    o_bv_r    <= o_bv_nxt;
    o_len_r   <= o_len_nxt;
    o_cur_r   <= o_cur_nxt;
    o_last_r  <= o_last_nxt;
  end

  assign out_valid          = (state_r == ST_OUT);
  assign out_found          = o_found_r;
  assign out_severity       = o_sev_r;
  assign out_byte           = o_byte_r;
  assign out_byte_valid     = o_bv_r;
  assign out_message_length = srlb_pkg::LEN_W'(o_len_r);
  assign out_new_cursor     = o_cur_r;
  assign out_last           = o_last_r;

endmodule

// ----- sv/srlb_checker.sv -----
// port-level checker for the ring log buffer and its bind
`include "assert_macros.svh"

module srlb_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_found,
  input logic                        out_byte_valid,
  input logic                        out_last
);

  // one transaction in flight at a time
  `SRLB_ASSERT(a_no_overlap, !(in_ready && out_valid), "ready while a result is pending")
  // stalled result stays
  `SRLB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped under stall")
  // final result frees the input side
  `SRLB_ASSERT_NEXT(a_last_frees, out_valid && out_ready && out_last, in_ready, "not ready after last")
  // idle block stays ready with no offer
  `SRLB_ASSERT_NEXT(a_idle_holds, in_ready && !in_valid, in_ready, "ready dropped while idle")
  // a miss is a single empty result
  `SRLB_ASSERT(a_miss_form, out_valid && !out_found |-> out_last && !out_byte_valid, "bad miss result")

endmodule

bind sequenced_ring_log_buffer srlb_checker u_srlb_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_found      (out_found),
  .out_byte_valid (out_byte_valid),
  .out_last       (out_last)
);
